// File: design/ulsd_pkg.sv
package ulsd_pkg;

    localparam int unsigned NumRates  = 31;
    localparam int unsigned QuoW      = 32;
    localparam int unsigned DenW      = 22;
    localparam int unsigned SpeedW    = 22;
    localparam int unsigned CfgIdxW   = 8;
    localparam int unsigned CfgDataW  = 32;
    localparam logic [SpeedW-1:0] ResetFallback = 22'd115200;

    localparam longint unsigned TolLo    = 9843;
    localparam longint unsigned TolHi    = 10157;
    // tolerance scale 10000 times the factor 4 applied to the quotient
    localparam longint unsigned TolScale = 40000;

    localparam logic [CfgIdxW-1:0] RegClockFreq = 8'd0;
    localparam logic [CfgIdxW-1:0] RegFallback  = 8'd1;

    localparam logic [1:0] WlenField8 = 2'b11;
    localparam logic [1:0] WlenField7 = 2'b10;
    localparam logic [1:0] WlenField6 = 2'b01;

    localparam logic [2:0] ParNone  = 3'd0;
    localparam logic [2:0] ParOdd   = 3'd1;
    localparam logic [2:0] ParEven  = 3'd2;
    localparam logic [2:0] ParMark  = 3'd3;
    localparam logic [2:0] ParSpace = 3'd4;

    typedef struct packed {
        logic [15:0] int_divisor;
        logic [5:0]  frac_divisor;
        logic [7:0]  line_control;
        logic [15:0] control_word;
    } in_t;

    typedef struct packed {
        logic [SpeedW-1:0] speed;
        logic [3:0]        word_length;
        logic [2:0]        parity;
        logic [1:0]        stop_count;
        logic              rts_dtr_off;
    } out_t;

    function automatic longint unsigned std_rate(int unsigned i);
        case (i)
            0: return 115200;   1: return 57600;    2: return 19200;
            3: return 9600;     4: return 50;       5: return 75;
            6: return 110;      7: return 134;      8: return 150;
            9: return 200;      10: return 300;     11: return 600;
            12: return 1200;    13: return 1800;    14: return 2400;
            15: return 4800;    16: return 38400;   17: return 76800;
            18: return 153600;  19: return 230400;  20: return 307200;
            21: return 460800;  22: return 921600;  23: return 1000000;
            24: return 1152000; 25: return 1500000; 26: return 2000000;
            27: return 2500000; 28: return 3000000; 29: return 3500000;
            default: return 4000000;
        endcase
    endfunction

    // smallest quotient whose scaled baud reaches the lower bound
    function automatic logic [QuoW-1:0] quo_lo(int unsigned i);
        return QuoW'((std_rate(i) * TolLo + TolScale - 1) / TolScale);
    endfunction

    function automatic logic [QuoW-1:0] quo_hi(int unsigned i);
        return QuoW'((std_rate(i) * TolHi) / TolScale);
    endfunction

endpackage

// File: design/uart_line_settings_decode_unit.sv
// UART line settings decode.
// Input channel s_valid/s_ready/s_data carries the divisor registers, line
// control byte and control word; result channel m_valid/m_ready/m_data
// carries speed, data bits, parity, stop bits and the RTS/DTR off flag.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data: index 0 is the reference clock in Hz, index 1 the fallback
// speed; other indexes are dropped. cfg_ready is always high.
// Throughput is one transaction per cycle unless the receiver stalls.
// Stages: one input register, 32 restoring-division stages (one quotient
// bit per stage) for clock / (ibrd*64 + fbrd), one stage comparing the
// quotient against the per-rate bounds, one picking the first matching rate.
// When the receiver stalls the whole pipeline holds in place and s_ready
// drops; bubbles still fill while the output register is empty.
// Reset clears all stage valid bits, sets the clock to zero (unknown) and
// the fallback speed to 115200.
module uart_line_settings_decode_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ulsd_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ulsd_pkg::out_t                   m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ulsd_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [ulsd_pkg::CfgDataW-1:0]    cfg_data
);

    localparam int unsigned QW = ulsd_pkg::QuoW;
    localparam int unsigned DW = ulsd_pkg::DenW;
    localparam int unsigned NR = ulsd_pkg::NumRates;

    // settings decoded at entry, carried alongside the division
    typedef struct packed {
        logic       zero_path;
        logic [3:0] word_length;
        logic [2:0] parity;
        logic [1:0] stop_count;
        logic       rts_dtr_off;
    } side_t;

    logic [31:0]                clk_freq_reg;
    logic [ulsd_pkg::SpeedW-1:0] fallback_reg;

    logic advance;

    logic          vld_reg  [0:QW];
    logic [QW-1:0] num_reg  [0:QW];
    logic [DW:0]   rem_reg  [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    side_t         side_reg [0:QW];

    logic          cmp_vld_reg;
    logic [NR-1:0] cmp_hit_reg;
    side_t         cmp_side_reg;

    logic           out_vld_reg;
    ulsd_pkg::out_t out_reg;

    assign cfg_ready = 1'b1;
    assign advance   = !out_vld_reg || m_ready;
    assign s_ready   = advance;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_freq_reg <= '0;
            fallback_reg <= ulsd_pkg::ResetFallback;
        end else if (cfg_valid) begin
            if (cfg_index == ulsd_pkg::RegClockFreq) begin
                clk_freq_reg <= cfg_data;
            end else if (cfg_index == ulsd_pkg::RegFallback) begin
                fallback_reg <= cfg_data[ulsd_pkg::SpeedW-1:0];
            end
        end
    end

    // entry stage: decode line control, form the divisor
    side_t side_next;
    always_comb begin
        side_next.zero_path = (clk_freq_reg == '0) || (s_data.int_divisor == '0);
        case (s_data.line_control[6:5])
            ulsd_pkg::WlenField8: side_next.word_length = 4'd8;
            ulsd_pkg::WlenField7: side_next.word_length = 4'd7;
            ulsd_pkg::WlenField6: side_next.word_length = 4'd6;
            default:              side_next.word_length = 4'd5;
        endcase
        if (!s_data.line_control[1]) begin
            side_next.parity = ulsd_pkg::ParNone;
        end else if (s_data.line_control[2]) begin
            side_next.parity = s_data.line_control[7] ? ulsd_pkg::ParSpace
                                                      : ulsd_pkg::ParEven;
        end else begin
            side_next.parity = s_data.line_control[7] ? ulsd_pkg::ParMark
                                                      : ulsd_pkg::ParOdd;
        end
        side_next.stop_count  = s_data.line_control[3] ? 2'd2 : 2'd1;
        side_next.rts_dtr_off = !(s_data.control_word[11] && s_data.control_word[10]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (advance) begin
            vld_reg[0] <= s_valid;
        end
        if (advance) begin
            num_reg[0]  <= clk_freq_reg;
            rem_reg[0]  <= '0;
            den_reg[0]  <= {s_data.int_divisor, s_data.frac_divisor};
            side_reg[0] <= side_next;
        end
    end

    // division stages: shift one dividend bit in, subtract if it fits
    for (genvar k = 1; k <= QW; k++) begin : g_div
        logic [DW+1:0] trial;
        logic          fits;
        assign trial = {rem_reg[k-1], num_reg[k-1][QW-1]};
        assign fits  = trial >= {2'b00, den_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (advance) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (advance) begin
                // quotient bits fill the freed low end of the dividend word
                num_reg[k]  <= {num_reg[k-1][QW-2:0], fits};
                rem_reg[k]  <= fits ? (DW+1)'(trial - {2'b00, den_reg[k-1]})
                                    : trial[DW:0];
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // compare the quotient against each rate's acceptance window
    logic [NR-1:0] hit_next;
    for (genvar r = 0; r < NR; r++) begin : g_cmp
        localparam logic [QW-1:0] Lo = ulsd_pkg::quo_lo(r);
        localparam logic [QW-1:0] Hi = ulsd_pkg::quo_hi(r);
        assign hit_next[r] = (num_reg[QW] >= Lo) && (num_reg[QW] <= Hi);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
        end else if (advance) begin
            cmp_vld_reg <= vld_reg[QW];
        end
        if (advance) begin
            cmp_hit_reg  <= side_reg[QW].zero_path ? '0 : hit_next;
            cmp_side_reg <= side_reg[QW];
        end
    end

    // first match in table order wins, else fallback
    ulsd_pkg::out_t out_next;
    always_comb begin
        out_next.speed = fallback_reg;
        for (int r = NR - 1; r >= 0; r--) begin
            if (cmp_hit_reg[r]) begin
                out_next.speed = ulsd_pkg::SpeedW'(ulsd_pkg::std_rate(r));
            end
        end
        out_next.word_length = cmp_side_reg.word_length;
        out_next.parity      = cmp_side_reg.parity;
        out_next.stop_count  = cmp_side_reg.stop_count;
        out_next.rts_dtr_off = cmp_side_reg.rts_dtr_off;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= cmp_vld_reg;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    a_word_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.word_length >= 4'd5 && m_data.word_length <= 4'd8))
        else $error("data bits out of range");

    a_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.parity <= ulsd_pkg::ParSpace))
        else $error("parity code out of range");

    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.stop_count == 2'd1 || m_data.stop_count == 2'd2))
        else $error("stop bits out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(cmp_hit_reg) && $stable(vld_reg[QW]))
        else $error("pipeline moved during stall");

endmodule
